>>> rtl/knn_top_k_search_core_macros.svh
// Assertion macros shared by the k-nearest-neighbor search core.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef KNN_TOP_K_SEARCH_CORE_MACROS_SVH
`define KNN_TOP_K_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define KNN_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("knn check failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define KNN_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("knn check failed: next-cycle implication");

`endif

>>> rtl/knn_pkg.sv
// Shared types and constants for the k-nearest-neighbor search core.
// No dependencies; imported by every module of the block except knn_ram.
package knn_pkg;

   localparam int COORD_BITS         = 16;
   localparam int INDEX_BITS         = 16;
   localparam int DIST_OUT_BITS      = 36;
   localparam int CFG_BITS           = 5;
   localparam int CSR_INDEX_BITS     = 1;
   localparam int CMD_BITS           = 2;
   localparam int REQ_DATA_BITS      = 16;
   localparam int RSP_DATA_BITS      = 56;
   localparam int MAX_DIMENSIONS_DEF = 16;
   localparam int MAX_NEIGHBORS_DEF  = 16;

   localparam logic [CFG_BITS-1:0] DIMENSIONS_RESET = 5'd14;
   localparam logic [CFG_BITS-1:0] NEIGHBORS_RESET  = 5'd3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_DIMENSIONS = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_NEIGHBORS  = 1'b1;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_QUERY     = 2'd0,
      CMD_REFERENCE = 2'd1,
      CMD_EMIT      = 2'd2
   } knn_cmd_type;

   // Operation handed from the distance pipeline to the neighbor list
   typedef struct packed {
      logic insert;
      logic clear;
      logic emit;
   } knn_op_type;

   // Control broadcast to every cell of the list
   typedef struct packed {
      logic insert;
      logic rotate;
      logic clear;
   } knn_cell_ctl_type;

endpackage

>>> rtl/knn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module knn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/knn_dist.sv
// Distance pipeline: query store, coordinate difference, square and accumulate.
// Depends on knn_pkg and knn_ram.
module knn_dist #(
   parameter int MAX_DIMENSIONS = 16,
   parameter int DIM_BITS = 5,
   parameter int DIST_BITS = 36
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               item_valid,
   input  knn_pkg::knn_cmd_type               item_cmd,
   input  logic [knn_pkg::COORD_BITS-1:0]     item_coord,
   input  logic [DIM_BITS-1:0]                dims,
   output knn_pkg::knn_op_type                op,
   output logic [DIST_BITS-1:0]               point_dist
);
   import knn_pkg::*;

   localparam int AW = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;

   typedef struct packed {
      logic ref_coord;
      logic clear;
      logic emit;
      logic point_end;
   } tag_type;

   logic [AW-1:0]           qpos_ff, qpos_in;
   logic [AW-1:0]           cpos_ff, cpos_in;
   logic [AW-1:0]           qsel, csel;
   logic [DIM_BITS-1:0]     qnext, cnext;
   logic                    wr_en, rd_en;
   tag_type                 tag0, tag1_ff, tag2_ff, tag3_ff;
   logic [COORD_BITS-1:0]   coord1_ff;
   logic [COORD_BITS-1:0]   query_q;
   logic [COORD_BITS-1:0]   diff2_ff;
   logic [2*COORD_BITS-1:0] sq3_ff;
   logic [DIST_BITS-1:0]    partial_ff, partial_in;
   logic [DIST_BITS-1:0]    sum;
   logic [DIST_BITS-1:0]    dist_ff, dist_in;
   knn_op_type              op_ff, op_in;

   // Position selection, wrapping when the dimension count has dropped
   always_comb begin
      qsel  = (DIM_BITS'(qpos_ff) >= dims) ? '0 : qpos_ff;
      csel  = (DIM_BITS'(cpos_ff) >= dims) ? '0 : cpos_ff;
      qnext = DIM_BITS'(qsel) + DIM_BITS'(1);
      cnext = DIM_BITS'(csel) + DIM_BITS'(1);
   end

   always_comb begin
      tag0    = '0;
      qpos_in = qpos_ff;
      cpos_in = cpos_ff;
      wr_en   = 1'b0;
      rd_en   = 1'b0;
      if (item_valid) begin
         unique case (item_cmd)
            CMD_QUERY: begin
               wr_en     = 1'b1;
               tag0.clear = 1'b1;
               cpos_in   = '0;
               qpos_in   = (qnext >= dims) ? '0 : AW'(qnext);
            end
            CMD_REFERENCE: begin
               rd_en          = 1'b1;
               tag0.ref_coord = 1'b1;
               tag0.point_end = (cnext >= dims);
               cpos_in        = (cnext >= dims) ? '0 : AW'(cnext);
            end
            CMD_EMIT: begin
               tag0.emit = 1'b1;
            end
            default: begin
               // unknown command: drop
            end
         endcase
      end
   end

   knn_ram #(
      .WIDTH (COORD_BITS),
      .DEPTH (MAX_DIMENSIONS),
      .ADDR_BITS (AW)
   ) u_query_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (qsel),
      .wr_data (item_coord),
      .rd_en   (rd_en),
      .rd_addr (csel),
      .rd_data (query_q)
   );

   // Accumulate stage; a clear token empties the running sum
   always_comb begin
      sum        = partial_ff + DIST_BITS'(sq3_ff);
      partial_in = partial_ff;
      dist_in    = dist_ff;
      op_in      = '0;
      op_in.clear = tag3_ff.clear;
      op_in.emit  = tag3_ff.emit;
      if (tag3_ff.clear) begin
         partial_in = '0;
      end else if (tag3_ff.ref_coord) begin
         if (tag3_ff.point_end) begin
            partial_in   = '0;
            dist_in      = sum;
            op_in.insert = 1'b1;
         end else begin
            partial_in = sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qpos_ff    <= '0;
         cpos_ff    <= '0;
         tag1_ff    <= '0;
         tag2_ff    <= '0;
         tag3_ff    <= '0;
         partial_ff <= '0;
         op_ff      <= '0;
      end else begin
         qpos_ff    <= qpos_in;
         cpos_ff    <= cpos_in;
         tag1_ff    <= tag0;
         tag2_ff    <= tag1_ff;
         tag3_ff    <= tag2_ff;
         partial_ff <= partial_in;
         op_ff      <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      coord1_ff <= item_coord;
      diff2_ff  <= (coord1_ff >= query_q) ? (coord1_ff - query_q) : (query_q - coord1_ff);
      sq3_ff    <= diff2_ff * diff2_ff;
      dist_ff   <= dist_in;
   end

   assign op         = op_ff;
   assign point_dist = dist_ff;

endmodule

>>> rtl/knn_cell.sv
// One slot of the sorted neighbor list: holds distance, index and valid flag.
// Depends on knn_pkg.
module knn_cell #(
   parameter int DIST_BITS = 36
) (
   input  logic                           clock,
   input  logic                           reset,
   input  knn_pkg::knn_cell_ctl_type      ctl,
   input  logic [DIST_BITS-1:0]           new_dist,
   input  logic [knn_pkg::INDEX_BITS-1:0] new_index,
   input  logic                           prev_take,
   input  logic                           prev_valid,
   input  logic [DIST_BITS-1:0]           prev_dist,
   input  logic [knn_pkg::INDEX_BITS-1:0] prev_index,
   input  logic                           next_valid,
   input  logic [DIST_BITS-1:0]           next_dist,
   input  logic [knn_pkg::INDEX_BITS-1:0] next_index,
   output logic                           take,
   output logic                           valid,
   output logic [DIST_BITS-1:0]           slot_dist,
   output logic [knn_pkg::INDEX_BITS-1:0] index
);
   import knn_pkg::*;

   logic                  valid_ff, valid_in;
   logic [DIST_BITS-1:0]  dist_ff, dist_in;
   logic [INDEX_BITS-1:0] index_ff, index_in;

   // Strict compare: an equal newcomer lands behind the stored point
   assign take = !valid_ff || (new_dist < dist_ff);

   always_comb begin
      valid_in = valid_ff;
      dist_in  = dist_ff;
      index_in = index_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.rotate) begin
         // advance toward the head so the list leaves nearest first
         valid_in = next_valid;
         dist_in  = next_dist;
         index_in = next_index;
      end else if (ctl.insert && take) begin
         if (prev_take) begin
            valid_in = prev_valid;
            dist_in  = prev_dist;
            index_in = prev_index;
         end else begin
            valid_in = 1'b1;
            dist_in  = new_dist;
            index_in = new_index;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff  <= dist_in;
      index_ff <= index_in;
   end

   assign valid     = valid_ff;
   assign slot_dist = dist_ff;
   assign index     = index_ff;

endmodule

>>> rtl/knn_top_k_search_core.sv
// Exact k-nearest-neighbor search, squared Euclidean distance, with sorted cell chain.
// Depends on knn_pkg, knn_dist, knn_cell and the assertion macro header.
//
// Query and reference coordinates are taken one per cycle, with no gaps, except while an
// emit holds req_tready low. The distance pipeline is four stages deep (query RAM read,
// difference, square, accumulate), and a reference point enters the neighbor list once
// its last coordinate has passed through all four; the list is a chain of MAX_NEIGHBORS
// cells. An emit transaction holds req_tready low from acceptance until the chain has
// rotated once through all cells; stalls on the result side lengthen that rotation.
// Results leave through an output register, nearest first; equal distances keep the
// earlier point first. Loading a query coordinate empties the list.
`include "knn_top_k_search_core_macros.svh"

module knn_top_k_search_core #(
   parameter int MAX_DIMENSIONS = knn_pkg::MAX_DIMENSIONS_DEF,
   parameter int MAX_NEIGHBORS  = knn_pkg::MAX_NEIGHBORS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request: tdata = coordinate[15:0]; tuser = command[1:0]
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [knn_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   input  logic [knn_pkg::CMD_BITS-1:0]          req_tuser,
   // response: tdata = distance_squared[35:0], neighbor_index[51:36], zero pad
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [knn_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   // response: tuser = found
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast,
   input  logic                                  csr_we,
   input  logic [knn_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [knn_pkg::CFG_BITS-1:0]          csr_wdata
);
   import knn_pkg::*;

   localparam int DIM_BITS  = $clog2(MAX_DIMENSIONS + 1);
   localparam int NBR_BITS  = $clog2(MAX_NEIGHBORS + 1);
   localparam int STEP_BITS = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
   localparam int DIST_BITS = 2 * COORD_BITS +
                              ((MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 0);
   localparam int COUNT_BITS = INDEX_BITS + 1;
   localparam int PAD_BITS  = RSP_DATA_BITS - DIST_OUT_BITS - INDEX_BITS;

   logic [CFG_BITS-1:0]   dims_cfg_ff, dims_cfg_in;
   logic [CFG_BITS-1:0]   nbr_cfg_ff, nbr_cfg_in;
   logic [DIM_BITS-1:0]   dims;
   logic [NBR_BITS-1:0]   k_use;
   logic                  accept;
   knn_cmd_type           cmd;
   knn_op_type            dist_op;
   logic [DIST_BITS-1:0]  point_dist;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  emit_busy_ff, emit_busy_in;
   logic                  rot_active_ff, rot_active_in;
   logic [STEP_BITS-1:0]  rot_step_ff, rot_step_in;
   logic                  need_out;
   logic                  can_step;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DIST_OUT_BITS-1:0] rsp_dist_ff, rsp_dist_in;
   logic [INDEX_BITS-1:0] rsp_index_ff, rsp_index_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [DIST_BITS+DIST_OUT_BITS-1:0] head_dist_wide;
   knn_cell_ctl_type      cell_ctl;

   logic                  cell_take  [MAX_NEIGHBORS];
   logic                  cell_valid [MAX_NEIGHBORS];
   logic [DIST_BITS-1:0]  cell_dist  [MAX_NEIGHBORS];
   logic [INDEX_BITS-1:0] cell_index [MAX_NEIGHBORS];

   // Configuration writes
   always_comb begin
      dims_cfg_in = dims_cfg_ff;
      nbr_cfg_in  = nbr_cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_DIMENSIONS: dims_cfg_in = csr_wdata;
            REG_NEIGHBORS:  nbr_cfg_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Clamp registers into their usable ranges
   always_comb begin
      if (dims_cfg_ff == '0) begin
         dims = DIM_BITS'(1);
      end else if (32'(dims_cfg_ff) > MAX_DIMENSIONS) begin
         dims = DIM_BITS'(MAX_DIMENSIONS);
      end else begin
         dims = DIM_BITS'(dims_cfg_ff);
      end
      if (nbr_cfg_ff == '0) begin
         k_use = NBR_BITS'(1);
      end else if (32'(nbr_cfg_ff) > MAX_NEIGHBORS) begin
         k_use = NBR_BITS'(MAX_NEIGHBORS);
      end else begin
         k_use = NBR_BITS'(nbr_cfg_ff);
      end
   end

   assign req_tready = !emit_busy_ff;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = knn_cmd_type'(req_tuser);

   knn_dist #(
      .MAX_DIMENSIONS (MAX_DIMENSIONS),
      .DIM_BITS       (DIM_BITS),
      .DIST_BITS      (DIST_BITS)
   ) u_dist (
      .clock      (clock),
      .reset      (reset),
      .item_valid (accept),
      .item_cmd   (cmd),
      .item_coord (req_tdata[COORD_BITS-1:0]),
      .dims       (dims),
      .op         (dist_op),
      .point_dist (point_dist)
   );

   // Emit rotation: every cell shifts one place per step; a full turn restores the list
   assign need_out = NBR_BITS'(rot_step_ff) < k_use;
   assign can_step = rot_active_ff && (!need_out || !rsp_valid_ff || rsp_tready);

   always_comb begin
      cell_ctl        = '0;
      cell_ctl.insert = dist_op.insert;
      cell_ctl.clear  = dist_op.clear;
      cell_ctl.rotate = can_step;
   end

   for (genvar g = 0; g < MAX_NEIGHBORS; g++) begin : g_cell
      localparam int P = (g == 0) ? MAX_NEIGHBORS - 1 : g - 1;
      localparam int N = (g == MAX_NEIGHBORS - 1) ? 0 : g + 1;
      knn_cell #(
         .DIST_BITS (DIST_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl),
         .new_dist   (point_dist),
         .new_index  (count_ff[INDEX_BITS-1:0]),
         .prev_take  ((g == 0) ? 1'b0 : cell_take[P]),
         .prev_valid (cell_valid[P]),
         .prev_dist  (cell_dist[P]),
         .prev_index (cell_index[P]),
         .next_valid (cell_valid[N]),
         .next_dist  (cell_dist[N]),
         .next_index (cell_index[N]),
         .take       (cell_take[g]),
         .valid      (cell_valid[g]),
         .slot_dist  (cell_dist[g]),
         .index      (cell_index[g])
      );
   end

   assign head_dist_wide = {{DIST_OUT_BITS{1'b0}}, cell_dist[0]};

   always_comb begin
      count_in      = count_ff;
      emit_busy_in  = emit_busy_ff;
      rot_active_in = rot_active_ff;
      rot_step_in   = rot_step_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_dist_in   = rsp_dist_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_last_in   = rsp_last_ff;

      if (dist_op.clear) begin
         count_in = '0;
      end else if (dist_op.insert && (count_ff != '1)) begin
         count_in = count_ff + COUNT_BITS'(1);
      end

      if (accept && (cmd == CMD_EMIT)) begin
         emit_busy_in = 1'b1;
      end

      if (dist_op.emit) begin
         rot_active_in = 1'b1;
         rot_step_in   = '0;
      end

      if (can_step) begin
         if (need_out) begin
            rsp_valid_in = 1'b1;
            rsp_found_in = cell_valid[0];
            rsp_dist_in  = cell_valid[0] ? head_dist_wide[DIST_OUT_BITS-1:0] : '0;
            rsp_index_in = cell_valid[0] ? cell_index[0] : '0;
            rsp_last_in  = (NBR_BITS'(rot_step_ff) + NBR_BITS'(1)) == k_use;
         end
         if (32'(rot_step_ff) == MAX_NEIGHBORS - 1) begin
            rot_active_in = 1'b0;
            emit_busy_in  = 1'b0;
         end else begin
            rot_step_in = rot_step_ff + STEP_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_cfg_ff   <= DIMENSIONS_RESET;
         nbr_cfg_ff    <= NEIGHBORS_RESET;
         count_ff      <= '0;
         emit_busy_ff  <= 1'b0;
         rot_active_ff <= 1'b0;
         rot_step_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         dims_cfg_ff   <= dims_cfg_in;
         nbr_cfg_ff    <= nbr_cfg_in;
         count_ff      <= count_in;
         emit_busy_ff  <= emit_busy_in;
         rot_active_ff <= rot_active_in;
         rot_step_ff   <= rot_step_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_dist_ff  <= rsp_dist_in;
      rsp_index_ff <= rsp_index_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_BITS{1'b0}}, rsp_index_ff, rsp_dist_ff};
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tlast  = rsp_last_ff;

   `KNN_ASSERT_IMP(a_no_accept_in_rotation, clock, reset, rot_active_ff, !req_tready)
   `KNN_ASSERT_IMP(a_rotate_alone, clock, reset, cell_ctl.rotate, !dist_op.insert && !dist_op.clear)
   `KNN_ASSERT_NXT(a_emit_starts_rotation, clock, reset, dist_op.emit, rot_active_ff && emit_busy_ff)

endmodule

>>> tb/tb.sv
// Self-checking testbench for knn_top_k_search_core: k-nearest-neighbor search over streamed points.
// Depends on knn_pkg and the core RTL. It predicts every emitted neighbor and checks each
// result transaction in order.
`timescale 1ns / 100ps

module tb;
   import knn_pkg::*;

   localparam int          MAX_DIMS     = MAX_DIMENSIONS_DEF;
   localparam int          MAX_NEAR     = MAX_NEIGHBORS_DEF;
   localparam int unsigned POINT_SAT    = (1 << (INDEX_BITS + 1)) - 1;
   localparam int          DRAIN_CYCLES = 40;
   localparam int          HOLD_CYCLES  = 400;
   localparam int          CYCLE_LIMIT  = 1000000;
   localparam logic [CMD_BITS-1:0] CMD_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [DIST_OUT_BITS-1:0] dist_sq;
      logic [INDEX_BITS-1:0]    idx;
      logic                     found;
      logic                     last;
   } neighbor_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata = '0;   // coordinate
   logic [CMD_BITS-1:0]       req_tuser = '0;   // command
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;        // distance_squared, neighbor_index, zero pad
   logic                      rsp_tuser;        // found
   logic                      rsp_tlast;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0]       csr_wdata = '0;

   // search state as the block should hold it
   logic [COORD_BITS-1:0]    query_coord [MAX_DIMS];
   int unsigned              next_query_slot;
   int unsigned              next_ref_slot;
   logic [36:0]              ref_accum;
   int unsigned              ref_points;
   logic [36:0]              near_dist [MAX_NEAR];
   logic [INDEX_BITS-1:0]    near_idx [MAX_NEAR];
   int unsigned              near_count;
   logic [CFG_BITS-1:0]      dims_reg;
   logic [CFG_BITS-1:0]      k_reg;

   neighbor_result_type pending_neighbors [$];

   int   error_count = 0;
   int   cycle_count = 0;
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   logic hold_go = 1'b0;
   int   hold_count = 0;

   knn_top_k_search_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // long receiver hold-off, armed by a one-cycle pulse on hold_go
   always @(posedge clock) begin
      if (hold_go) begin
         hold_count <= HOLD_CYCLES;
      end else if (hold_count != 0) begin
         hold_count <= hold_count - 1;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= (hold_count == 0) && ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic report_mismatch(input string what, input logic [63:0] expected_val,
                                  input logic [63:0] actual_val);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, expected_val,
               actual_val);
      error_count++;
   endtask

   always @(posedge clock) begin : check_results
      neighbor_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_neighbors.size() == 0) begin
            report_mismatch("unexpected result", '0, 64'(rsp_tdata));
         end else begin
            want = pending_neighbors.pop_front();
            if (rsp_tdata[35:0] !== want.dist_sq)
               report_mismatch("distance_squared", 64'(want.dist_sq), 64'(rsp_tdata[35:0]));
            if (rsp_tdata[51:36] !== want.idx)
               report_mismatch("neighbor_index", 64'(want.idx), 64'(rsp_tdata[51:36]));
            if (rsp_tuser !== want.found)
               report_mismatch("found", 64'(want.found), 64'(rsp_tuser));
            if (rsp_tlast !== want.last)
               report_mismatch("last", 64'(want.last), 64'(rsp_tlast));
         end
      end
   end

   function automatic int unsigned clamp_cfg(input logic [CFG_BITS-1:0] v, input int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return 32'(v);
   endfunction

   function automatic void clear_neighbors();
      for (int i = 0; i < MAX_NEAR; i++) begin
         near_dist[i] = '1;
         near_idx[i]  = '0;
      end
      near_count    = 0;
      ref_points    = 0;
      ref_accum     = '0;
      next_ref_slot = 0;
   endfunction

   task automatic predict_neighbors(input knn_cmd_type cmd, input logic [COORD_BITS-1:0] coord);
      int unsigned         dims;
      int unsigned         k;
      int unsigned         pos;
      logic [15:0]         q;
      logic [15:0]         diff;
      neighbor_result_type r;
      dims = clamp_cfg(dims_reg, MAX_DIMS);
      k    = clamp_cfg(k_reg, MAX_NEAR);
      case (cmd)
         CMD_QUERY: begin
            clear_neighbors();
            if (next_query_slot >= dims) next_query_slot = 0;
            query_coord[next_query_slot] = coord;
            next_query_slot++;
            if (next_query_slot >= dims) next_query_slot = 0;
         end
         CMD_REFERENCE: begin
            if (next_ref_slot >= dims) next_ref_slot = 0;
            q = query_coord[next_ref_slot];
            diff = (coord >= q) ? coord - q : q - coord;
            ref_accum = ref_accum + diff * diff;
            next_ref_slot++;
            if (next_ref_slot >= dims) begin
               // sorted insert; equal distances stay behind the earlier point
               pos = 0;
               while (pos < near_count && near_dist[pos] <= ref_accum) pos++;
               if (pos < MAX_NEAR) begin
                  if (near_count < MAX_NEAR) near_count++;
                  for (int i = near_count - 1; i > pos; i--) begin
                     near_dist[i] = near_dist[i-1];
                     near_idx[i]  = near_idx[i-1];
                  end
                  near_dist[pos] = ref_accum;
                  near_idx[pos]  = ref_points[INDEX_BITS-1:0];
               end
               if (ref_points < POINT_SAT) ref_points++;
               ref_accum     = '0;
               next_ref_slot = 0;
            end
         end
         CMD_EMIT: begin
            for (int i = 0; i < k; i++) begin
               r.found   = (i < near_count);
               r.dist_sq = r.found ? near_dist[i][35:0] : '0;
               r.idx     = r.found ? near_idx[i] : '0;
               r.last    = (i + 1 == k);
               pending_neighbors.push_back(r);
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_item(input knn_cmd_type cmd, input logic [COORD_BITS-1:0] coord);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= coord;
      do @(posedge clock); while (!req_tready);
      predict_neighbors(cmd, coord);
   endtask

   // drop valid, wait for every expected result, then let the pipeline drain
   task automatic settle_search();
      req_tvalid <= 1'b0;
      while (pending_neighbors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                 input logic [CFG_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_DIMENSIONS) dims_reg = value;
      else k_reg = value;
      @(posedge clock);
   endtask

   function automatic logic [COORD_BITS-1:0] pick_coord();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         2: return COORD_BITS'($urandom_range(3));
         default: return COORD_BITS'($urandom_range(65535));
      endcase
   endfunction

   task automatic test_reset_state();
      // emit before any point: three empty slots under the reset neighbor count
      send_item(CMD_EMIT, 16'h0000);
      send_item(knn_cmd_type'(CMD_UNKNOWN), 16'hffff);
      send_item(CMD_EMIT, 16'hffff);
      settle_search();
   endtask

   task automatic test_full_query();
      write_register(REG_DIMENSIONS, 5'd16);
      write_register(REG_NEIGHBORS, 5'd16);
      for (int i = 0; i < MAX_DIMS; i++) send_item(CMD_QUERY, i[0] ? 16'hffff : 16'h0000);
      // opposite corner: the largest distance the block can report
      for (int i = 0; i < MAX_DIMS; i++) send_item(CMD_REFERENCE, i[0] ? 16'h0000 : 16'hffff);
      settle_search();
      write_register(REG_DIMENSIONS, 5'd2);
      send_item(CMD_REFERENCE, 16'h0000);
      send_item(CMD_REFERENCE, 16'hffff);
      // two points at equal distance
      send_item(CMD_REFERENCE, 16'h0003);
      send_item(CMD_REFERENCE, 16'hffff);
      send_item(CMD_REFERENCE, 16'h0000);
      send_item(CMD_REFERENCE, 16'hfffc);
      send_item(CMD_EMIT, 16'h1234);
      send_item(CMD_EMIT, 16'h0000);
      settle_search();
   endtask

   task automatic test_dims_change();
      write_register(REG_DIMENSIONS, 5'd4);
      write_register(REG_NEIGHBORS, 5'd5);
      send_item(CMD_QUERY, 16'h0010);
      send_item(CMD_QUERY, 16'h0020);
      send_item(CMD_QUERY, 16'h0030);
      send_item(CMD_REFERENCE, 16'h0011);
      send_item(CMD_REFERENCE, 16'h0025);
      send_item(CMD_REFERENCE, 16'h0100);
      settle_search();
      // point in flight wraps to the first position once dimensions drop below its position
      write_register(REG_DIMENSIONS, 5'd2);
      send_item(CMD_REFERENCE, 16'h0012);
      send_item(CMD_REFERENCE, 16'h0022);
      send_item(CMD_EMIT, 16'h0000);
      settle_search();
      // query slot beyond the new dimensions wraps before the write
      write_register(REG_DIMENSIONS, 5'd4);
      send_item(CMD_QUERY, 16'h0001);
      send_item(CMD_QUERY, 16'h0002);
      send_item(CMD_QUERY, 16'h0003);
      settle_search();
      write_register(REG_DIMENSIONS, 5'd2);
      send_item(CMD_QUERY, 16'h0004);
      send_item(CMD_REFERENCE, 16'h0004);
      send_item(CMD_REFERENCE, 16'h0002);
      send_item(CMD_EMIT, 16'h0000);
      settle_search();
   endtask

   task automatic random_traffic(input int n_items);
      int sent;
      int dims;
      int pick;
      sent = 0;
      while (sent < n_items) begin
         dims = clamp_cfg(dims_reg, MAX_DIMS);
         pick = $urandom_range(99);
         if (pick < 8) begin
            for (int i = 0; i < dims; i++) send_item(CMD_QUERY, pick_coord());
            sent += dims;
         end else if (pick < 75) begin
            for (int i = 0; i < dims; i++) send_item(CMD_REFERENCE, pick_coord());
            sent += dims;
         end else if (pick < 90) begin
            send_item(CMD_EMIT, COORD_BITS'($urandom_range(65535)));
            sent++;
         end else begin
            send_item(knn_cmd_type'(CMD_BITS'($urandom_range(3))),
                      COORD_BITS'($urandom_range(65535)));
            sent++;
         end
      end
      settle_search();
   endtask

   task automatic test_random_phases();
      send_idle_pct = 0;  rsp_stall_pct = 0;
      write_register(REG_DIMENSIONS, 5'd16);
      write_register(REG_NEIGHBORS, 5'd16);
      random_traffic(55);
      send_idle_pct = 83; rsp_stall_pct = 0;
      write_register(REG_DIMENSIONS, 5'd1);
      write_register(REG_NEIGHBORS, 5'd1);
      random_traffic(45);
      send_idle_pct = 0;  rsp_stall_pct = 83;
      write_register(REG_DIMENSIONS, 5'd0);
      write_register(REG_NEIGHBORS, 5'd31);
      random_traffic(45);
      send_idle_pct = 33; rsp_stall_pct = 33;
      write_register(REG_DIMENSIONS, 5'd31);
      write_register(REG_NEIGHBORS, 5'd0);
      random_traffic(55);
      send_idle_pct = 0;  rsp_stall_pct = 0;
      write_register(REG_DIMENSIONS, 5'd3);
      write_register(REG_NEIGHBORS, 5'd7);
      random_traffic(30);
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_go <= 1'b1;
      @(posedge clock);
      hold_go <= 1'b0;
      // keep offering while results back up behind the stalled receiver
      send_item(CMD_EMIT, 16'h0000);
      for (int i = 0; i < 6; i++) send_item(CMD_REFERENCE, pick_coord());
      send_item(CMD_EMIT, 16'h0000);
      send_item(CMD_EMIT, 16'h0000);
      send_item(CMD_REFERENCE, pick_coord());
      settle_search();
   endtask

   initial begin
      for (int i = 0; i < MAX_DIMS; i++) query_coord[i] = '0;
      next_query_slot = 0;
      clear_neighbors();
      dims_reg = DIMENSIONS_RESET;
      k_reg    = NEIGHBORS_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_full_query();
      test_dims_change();
      test_random_phases();
      test_backpressure();
      settle_search();
      if (error_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
